// ===== rtl/fmrc_pkg.sv =====
package fmrc_pkg;

  // Table geometry
  localparam int unsigned NumRules  = 16;
  localparam int unsigned NumCrit   = 8;
  localparam int unsigned NumExtra  = 4;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned RuleW     = $clog2(NumRules);
  localparam int unsigned RuleCntW  = $clog2(NumRules + 1);
  localparam int unsigned CritW     = $clog2(NumCrit);
  localparam int unsigned CritCntW  = $clog2(NumCrit + 1);
  localparam int unsigned AddrW     = RuleW + CritW;
  localparam int unsigned MemDepth  = NumRules * NumCrit;

  // Datapath widths
  localparam int unsigned ValW      = 32;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned ProdW     = IdxW + 1 + ValW;
  localparam int unsigned SumW      = ProdW + 1;

  // Configuration register indexes
  localparam logic [2:0] CfgOriginX  = 3'd0;
  localparam logic [2:0] CfgOriginY  = 3'd1;
  localparam logic [2:0] CfgOriginZ  = 3'd2;
  localparam logic [2:0] CfgSpacingX = 3'd3;
  localparam logic [2:0] CfgSpacingY = 3'd4;
  localparam logic [2:0] CfgSpacingZ = 3'd5;

  localparam logic signed [ValW-1:0] SpacingReset = 32'sd65536;
  localparam logic signed [ValW-1:0] ValMax = 32'sh7fff_ffff;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;

  // Field codes of a criterion
  localparam logic [2:0] FieldX      = 3'd0;
  localparam logic [2:0] FieldY      = 3'd1;
  localparam logic [2:0] FieldZ      = 3'd2;
  localparam logic [2:0] FieldExtra0 = 3'd3;
  localparam logic [2:0] FieldExtra1 = 3'd4;
  localparam logic [2:0] FieldExtra2 = 3'd5;
  localparam logic [2:0] FieldExtra3 = 3'd6;

  typedef enum logic [1:0] {
    FUNC_CLASSIFY = 2'd0,
    FUNC_APPEND   = 2'd1,
    FUNC_CLEAR    = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STAT_MATCH   = 3'd0,
    STAT_NOMATCH = 3'd1,
    STAT_STORED  = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_CLEARED = 3'd4
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SUM,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]             code;
    logic                   lower;
    logic signed [ValW-1:0] limit;
  } crit_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic walk;
    logic append;
    logic clear;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_e func;
    logic  walk_done;
    logic  out_busy;
  } sts_t;

endpackage

// ===== rtl/first_match_region_classifier.sv =====
// First-match region classifier.
// Input channel (in_valid_i/in_ready_o) carries one item per transfer: a
// classify, an append of one criterion to a selection, or a clear of the
// whole table. Every item except the unused function code yields exactly
// one result transfer on the output channel (out_valid_o/out_ready_i).
// Configuration writes (cfg_valid_i, index, data) set the grid origin and
// spacing; cfg_ready_o is always high. Write them only while the block is idle.
// An append or clear passes through the decode and done states before its
// result is loaded into the output register. A classify passes through decode
// and sum, then walks the criterion table (one read port, 16 selections of 8
// criteria) one entry per cycle until done. One item is processed at a time:
// the next transfer is accepted only after the result is loaded into the
// output register.
// The output register holds a finished result while the receiver stalls;
// the next item is accepted meanwhile, and its result waits in the block
// (input ready low) until the output register frees up.
// Reset empties the table, clears all counts and restores origin 0 and
// spacing 1.0 on all axes.
module first_match_region_classifier (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [9:0]         point_ix_i,
  input  logic [9:0]         point_iy_i,
  input  logic [9:0]         point_iz_i,
  input  logic signed [31:0] extra_value_0_i,
  input  logic signed [31:0] extra_value_1_i,
  input  logic signed [31:0] extra_value_2_i,
  input  logic signed [31:0] extra_value_3_i,
  input  logic [3:0]         rule_slot_i,
  input  logic [2:0]         field_code_i,
  input  logic               bound_kind_i,
  input  logic signed [31:0] bound_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [3:0]         matched_rule_o
);
  import fmrc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  fmrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, coordinates and result registers
  fmrc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .point_ix_i      (point_ix_i),
    .point_iy_i      (point_iy_i),
    .point_iz_i      (point_iz_i),
    .extra_value_0_i (extra_value_0_i),
    .extra_value_1_i (extra_value_1_i),
    .extra_value_2_i (extra_value_2_i),
    .extra_value_3_i (extra_value_3_i),
    .rule_slot_i     (rule_slot_i),
    .field_code_i    (field_code_i),
    .bound_kind_i    (bound_kind_i),
    .bound_value_i   (bound_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .matched_rule_o  (matched_rule_o)
  );

endmodule

// ===== rtl/fmrc_ctrl.sv =====
module fmrc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fmrc_pkg::sts_t  sts_i,
  output fmrc_pkg::cmd_t  cmd_o
);
  import fmrc_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.func)
          FUNC_CLASSIFY: state_d = ST_SUM;
          FUNC_APPEND: begin
            cmd_o.append = 1'b1;
            state_d      = ST_DONE;
          end
          FUNC_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = ST_DONE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SUM: begin
        cmd_o.start = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/fmrc_dp.sv =====
module fmrc_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fmrc_pkg::cmd_t          cmd_i,
  output fmrc_pkg::sts_t          sts_o,
  input  logic                    cfg_valid_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  input  logic [1:0]              func_i,
  input  logic [9:0]              point_ix_i,
  input  logic [9:0]              point_iy_i,
  input  logic [9:0]              point_iz_i,
  input  logic signed [31:0]      extra_value_0_i,
  input  logic signed [31:0]      extra_value_1_i,
  input  logic signed [31:0]      extra_value_2_i,
  input  logic signed [31:0]      extra_value_3_i,
  input  logic [3:0]              rule_slot_i,
  input  logic [2:0]              field_code_i,
  input  logic                    bound_kind_i,
  input  logic signed [31:0]      bound_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic [3:0]              matched_rule_o
);
  import fmrc_pkg::*;

  // Configuration registers
  logic signed [ValW-1:0] origin_q  [NumAxes];
  logic signed [ValW-1:0] spacing_q [NumAxes];

  // Latched input item
  func_e                  func_q;
  logic [IdxW-1:0]        idx_q [NumAxes];
  logic signed [ValW-1:0] extra_q [NumExtra];
  logic [RuleW-1:0]       slot_q;
  crit_t                  new_crit_q;

  // Coordinate pipeline
  logic signed [ProdW-1:0] prod_d  [NumAxes];
  logic signed [ProdW-1:0] prod_q  [NumAxes];
  logic signed [SumW-1:0]  sum     [NumAxes];
  logic signed [ValW-1:0]  coord_d [NumAxes];
  logic signed [ValW-1:0]  coord_q [NumAxes];

  // Rule table
  crit_t                 mem [MemDepth];
  crit_t                 rd_q;
  logic [AddrW-1:0]      raddr;
  logic [AddrW-1:0]      waddr;
  logic [CritCntW-1:0]   counts_q [NumRules];
  logic [CritCntW-1:0]   counts_d [NumRules];
  logic [RuleCntW-1:0]   active_q, active_d;
  logic [RuleCntW-1:0]   slot_next;
  logic                  slot_full;

  // Walk counters
  logic [RuleCntW-1:0]   rule_q, rule_d;
  logic [CritCntW-1:0]   crit_q, crit_d;
  logic [CritCntW-1:0]   cur_cnt;
  logic signed [ValW-1:0] cur_val;
  logic                  crit_fail;
  logic                  walk_done;
  logic                  walk_hit;

  // Result
  stat_e                 res_status_q;
  logic [RuleW-1:0]      res_rule_q;
  logic                  out_valid_q;
  stat_e                 out_status_q;
  logic [RuleW-1:0]      out_rule_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        origin_q[a]  <= '0;
        spacing_q[a] <= SpacingReset;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOriginX:  origin_q[0]  <= cfg_data_i;
        CfgOriginY:  origin_q[1]  <= cfg_data_i;
        CfgOriginZ:  origin_q[2]  <= cfg_data_i;
        CfgSpacingX: spacing_q[0] <= cfg_data_i;
        CfgSpacingY: spacing_q[1] <= cfg_data_i;
        CfgSpacingZ: spacing_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q           <= func_e'(func_i);
      idx_q[0]         <= point_ix_i;
      idx_q[1]         <= point_iy_i;
      idx_q[2]         <= point_iz_i;
      extra_q[0]       <= extra_value_0_i;
      extra_q[1]       <= extra_value_1_i;
      extra_q[2]       <= extra_value_2_i;
      extra_q[3]       <= extra_value_3_i;
      slot_q           <= rule_slot_i;
      new_crit_q.code  <= field_code_i;
      new_crit_q.lower <= bound_kind_i;
      new_crit_q.limit <= bound_value_i;
    end
  end

  // Coordinates: index times spacing, then add origin and saturate
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      prod_d[a] = $signed({1'b0, idx_q[a]}) * spacing_q[a];
      sum[a]    = SumW'(origin_q[a]) + SumW'(prod_q[a]);
      if ((&sum[a][SumW-1:ValW-1]) || !(|sum[a][SumW-1:ValW-1])) begin
        coord_d[a] = sum[a][ValW-1:0];
      end else if (sum[a][SumW-1]) begin
        coord_d[a] = ValMin;
      end else begin
        coord_d[a] = ValMax;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    coord_q <= coord_d;
  end

  // Evaluate the criterion read for the current rule and slot
  assign cur_cnt = counts_q[rule_q[RuleW-1:0]];

  always_comb begin
    case (rd_q.code)
      FieldX:      cur_val = coord_q[0];
      FieldY:      cur_val = coord_q[1];
      FieldZ:      cur_val = coord_q[2];
      FieldExtra0: cur_val = extra_q[0];
      FieldExtra1: cur_val = extra_q[1];
      FieldExtra2: cur_val = extra_q[2];
      FieldExtra3: cur_val = extra_q[3];
      default:     cur_val = '0;
    endcase
  end

  assign crit_fail = rd_q.lower ? (cur_val < rd_q.limit) : (cur_val > rd_q.limit);
  assign walk_done = (rule_q >= active_q) || (crit_q >= cur_cnt);
  assign walk_hit  = (rule_q < active_q);

  // Advance the walk: next criterion on pass, next rule on fail
  always_comb begin
    rule_d = rule_q;
    crit_d = crit_q;
    if (cmd_i.start) begin
      rule_d = '0;
      crit_d = '0;
    end else if (cmd_i.walk && !walk_done) begin
      if (crit_fail) begin
        rule_d = rule_q + RuleCntW'(1);
        crit_d = '0;
      end else begin
        crit_d = crit_q + CritCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= '0;
      crit_q <= '0;
    end else begin
      rule_q <= rule_d;
      crit_q <= crit_d;
    end
  end

  // Table memory: read ahead at the next walk position
  assign raddr = {rule_d[RuleW-1:0], crit_d[CritW-1:0]};
  assign waddr = {slot_q, counts_q[slot_q][CritW-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !slot_full) begin
      mem[waddr] <= new_crit_q;
    end
    rd_q <= mem[raddr];
  end

  // Counts and table size
  assign slot_full = (counts_q[slot_q] >= CritCntW'(NumCrit));
  assign slot_next = RuleCntW'(slot_q) + RuleCntW'(1);

  always_comb begin
    counts_d = counts_q;
    active_d = active_q;
    if (cmd_i.clear) begin
      for (int r = 0; r < NumRules; r++) begin
        counts_d[r] = '0;
      end
      active_d = '0;
    end else if (cmd_i.append && !slot_full) begin
      counts_d[slot_q] = counts_q[slot_q] + CritCntW'(1);
      if (active_q < slot_next) begin
        active_d = slot_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRules; r++) begin
        counts_q[r] <= '0;
      end
      active_q <= '0;
    end else begin
      counts_q <= counts_d;
      active_q <= active_d;
    end
  end

  // Pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk && walk_done) begin
      res_status_q <= walk_hit ? STAT_MATCH : STAT_NOMATCH;
      res_rule_q   <= walk_hit ? rule_q[RuleW-1:0] : '0;
    end else if (cmd_i.append) begin
      res_status_q <= slot_full ? STAT_FULL : STAT_STORED;
      res_rule_q   <= '0;
    end else if (cmd_i.clear) begin
      res_status_q <= STAT_CLEARED;
      res_rule_q   <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_rule_q   <= res_rule_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign matched_rule_o = out_rule_q;

  assign sts_o.func      = func_q;
  assign sts_o.walk_done = walk_done;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule
